>>> hdl/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpr_pkg;

    localparam int RATE_W   = 32;
    localparam int FBDIV_W  = 12;
    localparam int FRAC_W   = 24;
    localparam int REFDIV_W = 6;
    localparam int POST_W   = 3;
    localparam int OUT_W    = 45;
    localparam int DIVP_W   = REFDIV_W + 2 * POST_W;
    localparam int MOD_W    = 4;

    localparam logic FUNC_RECALC = 1'b0;
    localparam logic FUNC_CALC   = 1'b1;

    localparam logic [MOD_W-1:0] DEC_BASE = 4'd10;
    localparam logic [MOD_W-1:0] DEC_NINE = 4'd9;

    typedef struct packed {
        logic             valid;
        logic             func;
        logic             byp;
        logic             err;
        logic [MOD_W-1:0] mod10;
    } ctrl_t;

endpackage
`default_nettype wire

>>> hdl/frac_pll_rate_calculator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------------
// config    | in        | cfg_we                 | cfg_data (ref_rate)
// command   | in        | start while busy low   | func, target_rate, pll_* fields
// result    | out       | done, one cycle        | out_rate, new_*, div_error, fb_overflow
//
// One beat enters every cycle; busy stays low.
// Results pass through the stage 1 and stage 2 registers, the one-bit-per-stage
// long division over DW = max(num width, 32 + FRAC_BITS) quotient bits, and the output registers.
// rst_n clears the valid bits and ref_rate; the receiver cannot stall.
module frac_pll_rate_calculator #(
    parameter int FRAC_BITS = 24
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [fpr_pkg::RATE_W-1:0]          cfg_data,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 func,
    input  wire  [fpr_pkg::RATE_W-1:0]          target_rate,
    input  wire  [fpr_pkg::FBDIV_W-1:0]         pll_fbdiv,
    input  wire  [fpr_pkg::FRAC_W-1:0]          pll_frac,
    input  wire  [fpr_pkg::REFDIV_W-1:0]        pll_refdiv,
    input  wire  [fpr_pkg::POST_W-1:0]          pll_postdiv_a,
    input  wire  [fpr_pkg::POST_W-1:0]          pll_postdiv_b,
    input  wire                                 pll_bypass,
    output logic                                done,
    output logic [fpr_pkg::OUT_W-1:0]           out_rate,
    output logic [fpr_pkg::FBDIV_W-1:0]         new_fbdiv,
    output logic [fpr_pkg::FRAC_W-1:0]          new_frac,
    output logic [fpr_pkg::REFDIV_W-1:0]        new_refdiv,
    output logic [fpr_pkg::POST_W-1:0]          new_postdiv_a,
    output logic [fpr_pkg::POST_W-1:0]          new_postdiv_b,
    output logic                                div_error,
    output logic                                fb_overflow
);
    import fpr_pkg::*;

    localparam int PFB_W  = RATE_W + FBDIV_W;
    localparam int PFR_W  = RATE_W + FRAC_W;
    localparam int NUM_W  = (PFR_W - FRAC_BITS > PFB_W) ? (PFR_W - FRAC_BITS + 1) : (PFB_W + 1);
    localparam int CALC_W = RATE_W + FRAC_BITS;
    localparam int DW     = (NUM_W > CALC_W) ? NUM_W : CALC_W;
    localparam int PA_W   = REFDIV_W + POST_W;

    logic [RATE_W-1:0]  ref_rate_reg;

    ctrl_t              s1_ctrl_reg;
    logic [RATE_W-1:0]  s1_r_reg;
    logic [RATE_W-1:0]  s1_target_reg;
    logic [PFB_W-1:0]   s1_pfb_reg;
    logic [PFR_W-1:0]   s1_pfr_reg;
    logic [PA_W-1:0]    s1_pa_reg;
    logic [POST_W-1:0]  s1_pb_reg;

    ctrl_t              s2_ctrl_next;
    ctrl_t              s2_ctrl_reg;
    logic [NUM_W-1:0]   num;
    logic [DIVP_W-1:0]  divp;
    logic [DW-1:0]      s2_a_next;
    logic [DW-1:0]      s2_a_reg;
    logic [RATE_W-1:0]  s2_d_next;
    logic [RATE_W-1:0]  s2_d_reg;

    ctrl_t              pc [0:DW];
    logic [DW-1:0]      pa [0:DW];
    logic [RATE_W-1:0]  prem [0:DW];
    logic [RATE_W-1:0]  pd [0:DW];

    ctrl_t              fin;
    logic [DW-1:0]      q;
    logic [RATE_W-1:0]  qi;
    logic [OUT_W-1:0]   qr;

    logic               done_reg;
    logic [OUT_W-1:0]   out_rate_reg;
    logic [FBDIV_W-1:0] new_fbdiv_reg;
    logic [FRAC_W-1:0]  new_frac_reg;
    logic               one_reg;
    logic               div_error_reg;
    logic               fb_overflow_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_rate_reg <= '0;
            s1_ctrl_reg  <= '0;
            s2_ctrl_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ref_rate_reg <= cfg_data;
            end
            s1_ctrl_reg <= '{valid: start & ~busy, func: func, byp: pll_bypass,
                             err: 1'b0, mod10: '0};
            s2_ctrl_reg <= s2_ctrl_next;
            done_reg    <= fin.valid;
        end
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        s1_r_reg      <= ref_rate_reg;
        s1_target_reg <= target_rate;
        s1_pfb_reg    <= ref_rate_reg * PFB_W'(pll_fbdiv);
        s1_pfr_reg    <= ref_rate_reg * PFR_W'(pll_frac);
        s1_pa_reg     <= PA_W'(pll_refdiv) * PA_W'(pll_postdiv_a);
        s1_pb_reg     <= pll_postdiv_b;
    end

    // stage 2: numerator, divisor, error
    always_comb
    begin
        num  = NUM_W'(s1_pfb_reg) + NUM_W'(s1_pfr_reg >> FRAC_BITS);
        divp = DIVP_W'(s1_pa_reg) * DIVP_W'(s1_pb_reg);
        s2_ctrl_next = s1_ctrl_reg;
        if (s1_ctrl_reg.func == FUNC_CALC)
        begin
            s2_a_next = DW'(s1_target_reg) << FRAC_BITS;
            s2_d_next = s1_r_reg;
            s2_ctrl_next.err = (s1_r_reg == '0);
        end
        else if (s1_ctrl_reg.byp)
        begin
            s2_a_next = DW'(s1_r_reg);
            s2_d_next = RATE_W'(1);
        end
        else
        begin
            s2_a_next = DW'(num);
            s2_d_next = RATE_W'(divp);
            s2_ctrl_next.err = (divp == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg <= s2_a_next;
        s2_d_reg <= s2_d_next;
    end

    assign pc[0]   = s2_ctrl_reg;
    assign pa[0]   = s2_a_reg;
    assign prem[0] = '0;
    assign pd[0]   = s2_d_reg;

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        fpr_div_stage #(
            .DW(DW)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl_in (pc[k]),
            .a_in    (pa[k]),
            .rem_in  (prem[k]),
            .d_in    (pd[k]),
            .ctrl_out(pc[k+1]),
            .a_out   (pa[k+1]),
            .rem_out (prem[k+1]),
            .d_out   (pd[k+1])
        );
    end

    // output stage
    always_comb
    begin
        fin = pc[DW];
        q   = pa[DW];
        qi  = RATE_W'(q >> FRAC_BITS);
        qr  = q[OUT_W-1:0] + OUT_W'((fin.mod10 == DEC_NINE) && !fin.byp);
    end

    always_ff @(posedge clk)
    begin
        out_rate_reg    <= '0;
        new_fbdiv_reg   <= '0;
        new_frac_reg    <= '0;
        one_reg         <= 1'b0;
        fb_overflow_reg <= 1'b0;
        div_error_reg   <= fin.err;
        if (!fin.err)
        begin
            if (fin.func == FUNC_CALC)
            begin
                new_fbdiv_reg   <= qi[FBDIV_W-1:0];
                new_frac_reg    <= FRAC_W'(q[FRAC_BITS-1:0]);
                one_reg         <= 1'b1;
                fb_overflow_reg <= |qi[RATE_W-1:FBDIV_W];
            end
            else
            begin
                out_rate_reg <= qr;
            end
        end
    end

    assign done          = done_reg;
    assign out_rate      = out_rate_reg;
    assign new_fbdiv     = new_fbdiv_reg;
    assign new_frac      = new_frac_reg;
    assign new_refdiv    = REFDIV_W'(one_reg);
    assign new_postdiv_a = POST_W'(one_reg);
    assign new_postdiv_b = POST_W'(one_reg);
    assign div_error     = div_error_reg;
    assign fb_overflow   = fb_overflow_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_error |-> out_rate == '0 && new_fbdiv == '0 && new_frac == '0)
        else $error("error beat carries nonzero result");
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_rate != '0 |-> new_refdiv == '0 && !fb_overflow)
        else $error("recalc and calc fields mixed");
    a_ovf_calc: assert property (@(posedge clk) disable iff (!rst_n)
        fb_overflow |-> new_postdiv_a == POST_W'(1) && !div_error)
        else $error("overflow outside calc");
`endif

endmodule
`default_nettype wire

>>> hdl/fpr_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module fpr_div_stage #(
    parameter int DW = 56
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  fpr_pkg::ctrl_t              ctrl_in,
    input  wire  [DW-1:0]                     a_in,
    input  wire  [fpr_pkg::RATE_W-1:0]        rem_in,
    input  wire  [fpr_pkg::RATE_W-1:0]        d_in,
    output fpr_pkg::ctrl_t                    ctrl_out,
    output logic [DW-1:0]                     a_out,
    output logic [fpr_pkg::RATE_W-1:0]        rem_out,
    output logic [fpr_pkg::RATE_W-1:0]        d_out
);
    import fpr_pkg::*;

    logic [RATE_W:0]   trial;
    logic              ge;
    logic [RATE_W:0]   diff;
    logic [MOD_W:0]    m2;
    ctrl_t             ctrl_next;
    ctrl_t             ctrl_reg;
    logic [DW-1:0]     a_next;
    logic [DW-1:0]     a_reg;
    logic [RATE_W-1:0] rem_next;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] d_reg;

    always_comb
    begin
        trial     = {rem_in, a_in[DW-1]};
        ge        = trial >= {1'b0, d_in};
        diff      = trial - {1'b0, d_in};
        rem_next  = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        a_next    = {a_in[DW-2:0], ge};
        m2        = {ctrl_in.mod10, ge};
        ctrl_next = ctrl_in;
        ctrl_next.mod10 = (m2 >= {1'b0, DEC_BASE}) ? MOD_W'(m2 - {1'b0, DEC_BASE})
                                                   : m2[MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        rem_reg <= rem_next;
        d_reg   <= d_in;
    end

    assign ctrl_out = ctrl_reg;
    assign a_out    = a_reg;
    assign rem_out  = rem_reg;
    assign d_out    = d_reg;

endmodule
`default_nettype wire
